// ===== sv/aec_pkg.sv =====
// Shared types and constants for the arithmetic encoder core.
// No dependencies; aec_out_if, aec_ctrl, aec_dp, the top level and the checker use this package.
package aec_pkg;

  localparam int PEND_W = 16;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;
  localparam int MAX_RESULTS = 16;
  localparam int EMIT_W = $clog2(MAX_RESULTS + 1);

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic upd;
    logic step;
    logic flush;
    logic fin;
  } aec_cmd_t;

  typedef struct packed {
    logic is_finish;
    logic tot_zero;
    logic div_done;
    logic ren_done;
    logic ren_emit;
    logic hold_valid;
    logic out_free;
  } aec_status_t;

endpackage

// ===== sv/aec_in_if.sv =====
// Input channel of the arithmetic encoder core: one encode or finish item a beat.
// Depends on nothing.
interface aec_in_if #(parameter int FREQ_BITS = 14);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [FREQ_BITS-1:0] freq_upper;
  logic [FREQ_BITS-1:0] freq_lower;
  logic [FREQ_BITS-1:0] freq_total;

  modport source (output valid, output operation, output freq_upper, output freq_lower,
                  output freq_total, input ready);
  modport sink (input valid, input operation, input freq_upper, input freq_lower,
                input freq_total, output ready);
endinterface

// ===== sv/aec_out_if.sv =====
// Result channel of the arithmetic encoder core: one emitted bit a beat.
// Depends on aec_pkg for the follow count width.
interface aec_out_if;
  logic                      valid;
  logic                      ready;
  logic                      out_bit;
  logic [aec_pkg::PEND_W-1:0] follow_count;
  logic                      last;

  modport source (output valid, output out_bit, output follow_count, output last,
                  input ready);
  modport sink (input valid, input out_bit, input follow_count, input last,
                output ready);
endinterface

// ===== sv/aec_div.sv =====
// Radix-2 restoring divider, one quotient bit per step.
// Stand-alone; sequenced by the encoder datapath.
module aec_div #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 14
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    trial = {rem, quo[DIVIDEND_W-1]};
    fits  = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (step) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/aec_ctrl.sv =====
// Sequencer of the arithmetic encoder core: accept, scale, divide, renormalise, flush, finish.
// Depends on aec_pkg for command and status structs.
module aec_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  aec_pkg::aec_status_t st,
  output aec_pkg::aec_cmd_t    cmd
);
  import aec_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_DIV   = 6'b000100,
    S_REN   = 6'b001000,
    S_FLUSH = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          if (st.is_finish) begin
            state_next = S_FIN;
          end else if (!st.tot_zero) begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.upd    = 1'b1;
          state_next = S_REN;
        end else begin
          cmd.div = 1'b1;
        end
      end
      S_REN: begin
        if (st.ren_done) begin
          state_next = st.hold_valid ? S_FLUSH : S_IDLE;
        end else if (!(st.ren_emit && st.hold_valid && !st.out_free)) begin
          cmd.step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/aec_dp.sv =====
// Datapath of the arithmetic encoder core: code interval, pending count,
// two serial dividers, held bit and output register. Depends on aec_pkg, aec_div.
module aec_dp #(
  parameter int CODE_BITS = 16,
  parameter int FREQ_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  aec_pkg::aec_cmd_t          cmd,
  output aec_pkg::aec_status_t       st,
  input  logic                       operation,
  input  logic [FREQ_BITS-1:0]       freq_upper,
  input  logic [FREQ_BITS-1:0]       freq_lower,
  input  logic [FREQ_BITS-1:0]       freq_total,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_bit,
  output logic [aec_pkg::PEND_W-1:0] follow_count,
  output logic                       out_last
);
  import aec_pkg::*;

  localparam int RANGE_W = CODE_BITS + 1;
  localparam int PROD_W  = RANGE_W + FREQ_BITS;
  localparam int DCNT_W  = $clog2(PROD_W + 1);
  localparam int IT_W    = $clog2(CODE_BITS + 1);
  localparam logic [CODE_BITS-1:0] HALF = {1'b1, {(CODE_BITS-1){1'b0}}};
  localparam logic [CODE_BITS-1:0] FQ   = HALF >> 1;
  localparam logic [CODE_BITS-1:0] TQ   = HALF | FQ;

  logic [CODE_BITS-1:0] code_low, code_high;
  logic [PEND_W-1:0]    pending;
  logic [FREQ_BITS-1:0] f_up, f_lo, f_tot;
  logic [DCNT_W-1:0]    div_cnt;
  logic [IT_W-1:0]      it_cnt;
  logic [EMIT_W-1:0]    emit_cnt;
  logic                 hold_valid;
  logic                 hold_bit;
  logic [PEND_W-1:0]    hold_count;

  logic [RANGE_W-1:0]   range;
  logic [PROD_W-1:0]    prod_up, prod_lo, q_up, q_lo;
  logic [PEND_W-1:0]    pend_inc;
  logic                 is_lower, is_upper, is_mid, emit, loop_end;
  logic [CODE_BITS-1:0] low_sub, high_sub;
  logic                 out_free;
  logic                 push;
  logic                 push_bit;
  logic [PEND_W-1:0]    push_count;
  logic                 push_last;

  always_comb begin
    range    = {1'b0, code_high - code_low} + RANGE_W'(1);
    prod_up  = PROD_W'(range) * PROD_W'(f_up);
    prod_lo  = PROD_W'(range) * PROD_W'(f_lo);
    pend_inc = (pending == PEND_MAX) ? pending : pending + PEND_W'(1);
    is_lower = code_high < HALF;
    is_upper = code_low >= HALF;
    is_mid   = (code_low >= FQ) && (code_high < TQ);
    emit     = is_lower || is_upper;
    loop_end = (it_cnt == IT_W'(CODE_BITS)) || (emit_cnt == EMIT_W'(MAX_RESULTS));
    if (is_lower) begin
      low_sub  = code_low;
      high_sub = code_high;
    end else if (is_upper) begin
      low_sub  = code_low - HALF;
      high_sub = code_high - HALF;
    end else begin
      low_sub  = code_low - FQ;
      high_sub = code_high - FQ;
    end
    out_free = !out_valid || out_ready;

    push       = 1'b0;
    push_bit   = hold_bit;
    push_count = hold_count;
    push_last  = 1'b0;
    if (cmd.step && emit && hold_valid) begin
      push = 1'b1;
    end else if (cmd.flush) begin
      push      = 1'b1;
      push_last = 1'b1;
    end else if (cmd.fin) begin
      push       = 1'b1;
      push_bit   = code_low >= FQ;
      push_count = pend_inc;
      push_last  = 1'b1;
    end

    st.is_finish  = operation == OP_FINISH;
    st.tot_zero   = freq_total == '0;
    st.div_done   = div_cnt == DCNT_W'(PROD_W);
    st.ren_done   = loop_end || !(emit || is_mid);
    st.ren_emit   = emit;
    st.hold_valid = hold_valid;
    st.out_free   = out_free;
  end

  aec_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(FREQ_BITS)) u_div_up (
    .clk      (clk),
    .load     (cmd.mul),
    .step     (cmd.div),
    .dividend (prod_up),
    .divisor  (f_tot),
    .quotient (q_up)
  );

  aec_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(FREQ_BITS)) u_div_lo (
    .clk      (clk),
    .load     (cmd.mul),
    .step     (cmd.div),
    .dividend (prod_lo),
    .divisor  (f_tot),
    .quotient (q_lo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      code_low   <= '0;
      code_high  <= '1;
      pending    <= '0;
      div_cnt    <= '0;
      it_cnt     <= '0;
      emit_cnt   <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.mul) begin
        div_cnt <= '0;
      end else if (cmd.div) begin
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      if (cmd.upd) begin
        code_high <= code_low + q_up[CODE_BITS-1:0] - CODE_BITS'(1);
        code_low  <= code_low + q_lo[CODE_BITS-1:0];
        it_cnt    <= '0;
        emit_cnt  <= '0;
      end
      if (cmd.step) begin
        it_cnt    <= it_cnt + IT_W'(1);
        code_low  <= {low_sub[CODE_BITS-2:0], 1'b0};
        code_high <= {high_sub[CODE_BITS-2:0], 1'b1};
        if (emit) begin
          hold_valid <= 1'b1;
          pending    <= '0;
          emit_cnt   <= emit_cnt + EMIT_W'(1);
        end else begin
          pending <= pend_inc;
        end
      end
      if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if (cmd.fin) begin
        pending <= '0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_up  <= freq_upper;
      f_lo  <= freq_lower;
      f_tot <= freq_total;
    end
    if (cmd.step && emit) begin
      hold_bit   <= !is_lower;
      hold_count <= pending;
    end
    if (push) begin
      out_bit      <= push_bit;
      follow_count <= push_count;
      out_last     <= push_last;
    end
  end

endmodule

// ===== sv/arithmetic_encoder_core.sv =====
// Arithmetic encoder core: sequencer plus datapath.
// Depends on aec_pkg, aec_in_if, aec_out_if, aec_ctrl, aec_dp, aec_div.
//
// Usage:
//   item carries one beat per symbol: operation encode with the symbol's
//   cumulative interval [freq_lower, freq_upper) out of freq_total, or
//   operation finish. result carries one beat per emitted code bit, with
//   follow_count inverted bits to append after it; last marks the final
//   beat caused by an item.
//   An encode item is accepted, the range is scaled, the two serial dividers
//   run, the interval is updated, renormalisation steps (up to CODE_BITS)
//   run until the loop closes, and a held last bit is then released. A
//   finish item is accepted and emits one final beat. An encode item with
//   zero total is taken with no beat.
//   Renormalisation holds while a step would push the held bit and the result
//   register is full and stalled; item.ready is high only between items.
//   Reset returns the interval to [0, all ones], clears the pending count
//   and drops any result not yet taken.
module arithmetic_encoder_core #(
  parameter int CODE_BITS = 16,
  parameter int FREQ_BITS = 14
) (
  input  logic      clk,
  input  logic      rst,
  aec_in_if.sink    item,
  aec_out_if.source result
);
  import aec_pkg::*;

  aec_cmd_t    cmd;
  aec_status_t st;

  aec_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .st         (st),
    .cmd        (cmd)
  );

  aec_dp #(.CODE_BITS(CODE_BITS), .FREQ_BITS(FREQ_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .operation    (item.operation),
    .freq_upper   (item.freq_upper),
    .freq_lower   (item.freq_lower),
    .freq_total   (item.freq_total),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_bit      (result.out_bit),
    .follow_count (result.follow_count),
    .out_last     (result.last)
  );

endmodule

// ===== sv/aec_checker.sv =====
// Port-level checks for the arithmetic encoder core, bound to the top level.
// Depends on aec_pkg and arithmetic_encoder_core.
module aec_checker #(
  parameter int FREQ_BITS = 14
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_operation,
  input logic [FREQ_BITS-1:0]       in_freq_total,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_bit,
  input logic [aec_pkg::PEND_W-1:0] follow_count,
  input logic                       out_last
);
  import aec_pkg::*;

  // hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bit) && $stable(follow_count)
      && $stable(out_last))
    else $error("stalled result beat changed");

  // drop ready after any item that starts work
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !(in_operation == OP_ENCODE && in_freq_total == '0)
      |=> !in_ready)
    else $error("item accepted while previous item still in work");

  // a non-final beat only waits while its item is still in work
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("non-final beat outstanding between items");

  // come out of reset idle and empty
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind arithmetic_encoder_core aec_checker #(.FREQ_BITS(FREQ_BITS)) u_aec_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item.valid),
  .in_ready      (item.ready),
  .in_operation  (item.operation),
  .in_freq_total (item.freq_total),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_bit       (result.out_bit),
  .follow_count  (result.follow_count),
  .out_last      (result.last)
);
